// File: hw/rtl/vfcm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfcm_pkg
// Shared types, codes and constants of the voxel face cull mesher.
// ----------------------------------------------------------------------------
package vfcm_pkg;

  localparam int DEF_MAX_X = 16;
  localparam int DEF_MAX_Y = 64;
  localparam int DEF_MAX_Z = 16;

  localparam int SIZE_X_W = 5;
  localparam int SIZE_Y_W = 7;
  localparam int SIZE_Z_W = 5;
  localparam int EXT_W    = 9;
  localparam int POS_X_W  = 4;
  localparam int POS_Y_W  = 6;
  localparam int POS_Z_W  = 4;
  localparam int CRN_X_W  = 5;
  localparam int CRN_Y_W  = 7;
  localparam int CRN_Z_W  = 5;
  localparam int QUAD_W   = 17;
  localparam int SIDE_W   = 3;
  localparam int NSIDES   = 6;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 7;

  localparam logic [SIZE_X_W-1:0] RST_SIZE_X = 5'd16;
  localparam logic [SIZE_Y_W-1:0] RST_SIZE_Y = 7'd64;
  localparam logic [SIZE_Z_W-1:0] RST_SIZE_Z = 5'd16;

  localparam logic [CFG_IW-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IW-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IW-1:0] REG_SIZE_Z = 2'd2;

  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_MESH    = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  localparam logic [SIDE_W-1:0] SIDE_TOP    = 3'd0;
  localparam logic [SIDE_W-1:0] SIDE_BOTTOM = 3'd1;
  localparam logic [SIDE_W-1:0] SIDE_FRONT  = 3'd2;
  localparam logic [SIDE_W-1:0] SIDE_BACK   = 3'd3;
  localparam logic [SIDE_W-1:0] SIDE_RIGHT  = 3'd4;
  localparam logic [SIDE_W-1:0] SIDE_LEFT   = 3'd5;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_MESH    = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic [SIZE_X_W-1:0] size_x;
    logic [SIZE_Y_W-1:0] size_y;
    logic [SIZE_Z_W-1:0] size_z;
  } cfg_t;

  // one queued command; nb_in flags neighbors inside the chunk, per side
  typedef struct packed {
    cmd_kind_t            kind;
    logic [POS_X_W-1:0]   x;
    logic [POS_Y_W-1:0]   y;
    logic [POS_Z_W-1:0]   z;
    logic                 occ;
    logic [NSIDES-1:0]    nb_in;
  } cmd_t;

  // face origin offset {x,y,z} per side
  function automatic logic [2:0] corner_ofs(input logic [SIDE_W-1:0] side);
    logic [2:0] ofs;
    case (side)
      SIDE_TOP:    ofs = 3'b010;
      SIDE_BOTTOM: ofs = 3'b001;
      SIDE_FRONT:  ofs = 3'b011;
      SIDE_BACK:   ofs = 3'b000;
      SIDE_RIGHT:  ofs = 3'b100;
      SIDE_LEFT:   ofs = 3'b010;
      default:     ofs = 3'b000;
    endcase
    return ofs;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/vfcm_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfcm interfaces
// Request, face and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface vfcm_req_if import vfcm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [POS_X_W-1:0] pos_x;
  logic [POS_Y_W-1:0] pos_y;
  logic [POS_Z_W-1:0] pos_z;
  logic               occupied;
  modport source (output valid, req_type, pos_x, pos_y, pos_z, occupied, input ready);
  modport sink   (input valid, req_type, pos_x, pos_y, pos_z, occupied, output ready);
endinterface

interface vfcm_face_if import vfcm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SIDE_W-1:0]  face_side;
  logic [CRN_X_W-1:0] corner_x;
  logic [CRN_Y_W-1:0] corner_y;
  logic [CRN_Z_W-1:0] corner_z;
  logic [QUAD_W-1:0]  quad_index;
  logic               last;
  modport source (output valid, face_side, corner_x, corner_y, corner_z, quad_index, last,
                  input ready);
  modport sink   (input valid, face_side, corner_x, corner_y, corner_z, quad_index, last,
                  output ready);
endinterface

interface vfcm_cfg_if import vfcm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/vfcm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfcm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vfcm_ram #(
  parameter  int WIDTH = 1,
  parameter  int DEPTH = 2,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hw/rtl/vfcm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfcm_front
// Accepts request words, checks chunk bounds, queues commands for the back end.
// ----------------------------------------------------------------------------
module vfcm_front import vfcm_pkg::*; #(
  parameter int MAX_X = DEF_MAX_X,
  parameter int MAX_Y = DEF_MAX_Y,
  parameter int MAX_Z = DEF_MAX_Z
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  vfcm_req_if.sink   req,
  output logic       q_valid,
  input  wire logic  q_ready,
  output cmd_t       q_cmd
);

  localparam int QD = 2;

  logic [EXT_W-1:0] eff_x, eff_y, eff_z;
  logic [EXT_W-1:0] px, py, pz;
  logic             ctr_in;
  logic             keep;
  logic             push, pop;
  cmd_t             cmd_in;

  cmd_t       q_mem [QD];
  logic       wr_ptr, rd_ptr;
  logic [1:0] q_cnt;

  always_comb begin
    eff_x = (EXT_W'(cfg.size_x) > EXT_W'(MAX_X)) ? EXT_W'(MAX_X) : EXT_W'(cfg.size_x);
    eff_y = (EXT_W'(cfg.size_y) > EXT_W'(MAX_Y)) ? EXT_W'(MAX_Y) : EXT_W'(cfg.size_y);
    eff_z = (EXT_W'(cfg.size_z) > EXT_W'(MAX_Z)) ? EXT_W'(MAX_Z) : EXT_W'(cfg.size_z);
    px = EXT_W'(req.pos_x);
    py = EXT_W'(req.pos_y);
    pz = EXT_W'(req.pos_z);
    ctr_in = (px < eff_x) && (py < eff_y) && (pz < eff_z);

    cmd_in.x   = req.pos_x;
    cmd_in.y   = req.pos_y;
    cmd_in.z   = req.pos_z;
    cmd_in.occ = req.occupied;
    cmd_in.nb_in[SIDE_TOP]    = (py + EXT_W'(1)) < eff_y;
    cmd_in.nb_in[SIDE_BOTTOM] = (py != '0);
    cmd_in.nb_in[SIDE_FRONT]  = (pz + EXT_W'(1)) < eff_z;
    cmd_in.nb_in[SIDE_BACK]   = (pz != '0);
    cmd_in.nb_in[SIDE_RIGHT]  = (px + EXT_W'(1)) < eff_x;
    cmd_in.nb_in[SIDE_LEFT]   = (px != '0);

    case (req.req_type)
      REQ_WRITE: begin
        cmd_in.kind = CMD_WRITE;
        keep        = ctr_in;
      end
      REQ_MESH: begin
        cmd_in.kind = CMD_MESH;
        keep        = ctr_in;
      end
      REQ_RESTART: begin
        cmd_in.kind = CMD_RESTART;
        keep        = 1'b1;
      end
      default: begin
        cmd_in.kind = CMD_RESTART;
        keep        = 1'b0;
      end
    endcase
  end

  assign req.ready = (q_cnt != 2'(QD));
  assign push      = req.valid && req.ready && keep;
  assign q_valid   = (q_cnt != '0);
  assign pop       = q_valid && q_ready;
  assign q_cmd     = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      q_cnt  <= '0;
    end else begin
      if (push) begin
        q_mem[wr_ptr] <= cmd_in;
        wr_ptr        <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        q_cnt <= q_cnt + 2'd1;
      end else if (pop && !push) begin
        q_cnt <= q_cnt - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/vfcm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfcm_back
// Executes queued commands: occupancy writes, counter restart, and face
// culling of one voxel through seven grid reads and a face output register.
// ----------------------------------------------------------------------------
module vfcm_back import vfcm_pkg::*; #(
  parameter int MAX_X = DEF_MAX_X,
  parameter int MAX_Y = DEF_MAX_Y,
  parameter int MAX_Z = DEF_MAX_Z
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_valid,
  output logic       q_ready,
  input  wire cmd_t  q_cmd,
  vfcm_face_if.source face
);

  localparam int CELLS    = MAX_X * MAX_Y * MAX_Z;
  localparam int AW       = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int STRIDE_Y = MAX_X;
  localparam int STRIDE_Z = MAX_X * MAX_Y;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  function automatic logic [AW-1:0] cell_addr(input logic [POS_X_W-1:0] x,
                                              input logic [POS_Y_W-1:0] y,
                                              input logic [POS_Z_W-1:0] z);
    return AW'(32'(x) + 32'(STRIDE_Y) * 32'(y) + 32'(STRIDE_Z) * 32'(z));
  endfunction

  state_t             state;
  cmd_t               cmd;
  logic [2:0]         rd_cnt;
  logic               solid;
  logic [NSIDES-1:0]  exposed;
  logic [NSIDES-1:0]  exposed_upd;
  logic [NSIDES-1:0]  remain;
  logic [SIDE_W-1:0]  pick;
  logic [2:0]         ofs;
  logic [QUAD_W-1:0]  face_count;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  logic [AW-1:0]      ctr_addr;
  logic               ram_rdata;

  logic               out_valid;
  logic               out_load;
  logic [SIDE_W-1:0]  out_side;
  logic [CRN_X_W-1:0] out_cx;
  logic [CRN_Y_W-1:0] out_cy;
  logic [CRN_Z_W-1:0] out_cz;
  logic [QUAD_W-1:0]  out_quad;
  logic               out_last;

  vfcm_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_cmd.occ),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    q_ready   = (state == ST_IDLE);
    ram_we    = q_valid && q_ready && (q_cmd.kind == CMD_WRITE);
    ram_waddr = cell_addr(q_cmd.x, q_cmd.y, q_cmd.z);
    ctr_addr  = cell_addr(cmd.x, cmd.y, cmd.z);

    // read order: center, then top..left; outside neighbors re-read center
    case (rd_cnt)
      3'd1:    ram_raddr = cmd.nb_in[SIDE_TOP]    ? ctr_addr + AW'(STRIDE_Y) : ctr_addr;
      3'd2:    ram_raddr = cmd.nb_in[SIDE_BOTTOM] ? ctr_addr - AW'(STRIDE_Y) : ctr_addr;
      3'd3:    ram_raddr = cmd.nb_in[SIDE_FRONT]  ? ctr_addr + AW'(STRIDE_Z) : ctr_addr;
      3'd4:    ram_raddr = cmd.nb_in[SIDE_BACK]   ? ctr_addr - AW'(STRIDE_Z) : ctr_addr;
      3'd5:    ram_raddr = cmd.nb_in[SIDE_RIGHT]  ? ctr_addr + AW'(1) : ctr_addr;
      3'd6:    ram_raddr = cmd.nb_in[SIDE_LEFT]   ? ctr_addr - AW'(1) : ctr_addr;
      default: ram_raddr = ctr_addr;
    endcase

    exposed_upd = exposed;
    for (int i = 0; i < NSIDES; i++) begin
      if (rd_cnt == 3'(i + 2)) begin
        exposed_upd[i] = ~(cmd.nb_in[i] & ram_rdata);
      end
    end

    pick = '0;
    for (int i = NSIDES - 1; i >= 0; i--) begin
      if (exposed[i]) begin
        pick = SIDE_W'(i);
      end
    end
    remain   = exposed & ~(NSIDES'(1) << pick);
    ofs      = corner_ofs(pick);
    out_load = (state == ST_EMIT) && (!out_valid || face.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rd_cnt     <= '0;
      face_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (face.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            case (q_cmd.kind)
              CMD_RESTART: face_count <= '0;
              CMD_MESH: begin
                cmd     <= q_cmd;
                rd_cnt  <= '0;
                exposed <= '0;
                state   <= ST_READ;
              end
              default: ;
            endcase
          end
        end
        ST_READ: begin
          rd_cnt  <= rd_cnt + 3'd1;
          exposed <= exposed_upd;
          if (rd_cnt == 3'd1) begin
            solid <= ram_rdata;
          end
          if (rd_cnt == 3'd7) begin
            state <= (solid && (exposed_upd != '0)) ? ST_EMIT : ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            out_side   <= pick;
            out_cx     <= CRN_X_W'(cmd.x) + CRN_X_W'(ofs[2]);
            out_cy     <= CRN_Y_W'(cmd.y) + CRN_Y_W'(ofs[1]);
            out_cz     <= CRN_Z_W'(cmd.z) + CRN_Z_W'(ofs[0]);
            out_quad   <= face_count;
            out_last   <= (remain == '0);
            face_count <= face_count + QUAD_W'(1);
            exposed    <= remain;
            if (remain == '0) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign face.valid      = out_valid;
  assign face.face_side  = out_side;
  assign face.corner_x   = out_cx;
  assign face.corner_y   = out_cy;
  assign face.corner_z   = out_cz;
  assign face.quad_index = out_quad;
  assign face.last       = out_last;

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    out_load |=> face_count == $past(face_count) + QUAD_W'(1))
    else $error("face counter did not advance by one per face");

  a_mask_shrinks: assert property (@(posedge clk) disable iff (rst)
    out_load |=> $countones(exposed) == $countones($past(exposed)) - 1)
    else $error("exposed mask did not drop exactly one side");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == ST_IDLE && q_cmd.kind == CMD_WRITE)
    else $error("grid write outside idle");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_load && remain == '0) |=> state == ST_IDLE && face.valid && face.last)
    else $error("last face did not close the voxel");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> exposed != '0)
    else $error("emit state with no exposed side");

endmodule
`default_nettype wire

// File: hw/rtl/voxel_face_cull_mesher_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_face_cull_mesher_unit
// Voxel chunk occupancy grid with per-voxel face culling.
// ----------------------------------------------------------------------------
// Channels: req carries words of type write (store one occupancy bit), mesh
// (cull one voxel) or restart (clear the quad counter). face returns one word
// per exposed face of a meshed, occupied voxel, order top, bottom, front,
// back, right, left, with last set on the final one. cfg writes the chunk
// extent registers size_x, size_y, size_z (always ready).
// Flow: a front queue of two words takes requests while the back end works.
// Write and restart are done in the idle state. A mesh word leaves the queue,
// then the grid is read (center plus six neighbors, one read port with
// registered data) and one face word is emitted per exposed face.
// Write and mesh requests outside the chunk and unknown types are dropped on acceptance.
// Reset: extent registers return to 16 x 64 x 16, the quad counter clears,
// the queue empties. The occupancy grid is not cleared; cells must be written
// before a mesh reads them.
// Stall: the face output register holds its word until taken; the back end
// then waits, the queue fills and req.ready drops.
// ----------------------------------------------------------------------------
module voxel_face_cull_mesher_unit import vfcm_pkg::*; #(
  parameter int MAX_X = DEF_MAX_X,
  parameter int MAX_Y = DEF_MAX_Y,
  parameter int MAX_Z = DEF_MAX_Z
) (
  input  wire logic   clk,
  input  wire logic   rst,
  vfcm_req_if.sink    req,
  vfcm_face_if.source face,
  vfcm_cfg_if.sink    cfg
);

  cfg_t cfg_q;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.size_x <= RST_SIZE_X;
      cfg_q.size_y <= RST_SIZE_Y;
      cfg_q.size_z <= RST_SIZE_Z;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SIZE_X: cfg_q.size_x <= cfg.data[SIZE_X_W-1:0];
        REG_SIZE_Y: cfg_q.size_y <= cfg.data[SIZE_Y_W-1:0];
        REG_SIZE_Z: cfg_q.size_z <= cfg.data[SIZE_Z_W-1:0];
        default: ;
      endcase
    end
  end

  vfcm_front #(
    .MAX_X (MAX_X),
    .MAX_Y (MAX_Y),
    .MAX_Z (MAX_Z)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_q),
    .req     (req),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_cmd   (q_cmd)
  );

  vfcm_back #(
    .MAX_X (MAX_X),
    .MAX_Y (MAX_Y),
    .MAX_Z (MAX_Z)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_cmd   (q_cmd),
    .face    (face)
  );

endmodule
`default_nettype wire

// File: verif/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Checks the voxel face cull mesher against a cycle-free predictor of the
// occupancy grid and the quad counter. Directed words hit the chunk corners,
// a fully hidden voxel, counter restart, unknown words and extent extremes.
// Random phases then sweep several extents. Request and face channels idle
// at random, and every face word is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import vfcm_pkg::*;

  localparam int WATCH_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_WORDS   = 66;
  localparam int GRID_CELLS    = DEF_MAX_X * DEF_MAX_Y * DEF_MAX_Z;

  localparam logic [1:0]        REQ_UNKNOWN = 2'd3;
  localparam logic [CFG_IW-1:0] REG_SPARE   = 2'd3;

  // per side, in emit order: neighbor step and face origin offset
  localparam logic [SIDE_W-1:0] SIDE_SEQ [NSIDES] =
    '{SIDE_TOP, SIDE_BOTTOM, SIDE_FRONT, SIDE_BACK, SIDE_RIGHT, SIDE_LEFT};
  localparam int STEP_X [NSIDES] = '{0, 0, 0, 0, 1, -1};
  localparam int STEP_Y [NSIDES] = '{1, -1, 0, 0, 0, 0};
  localparam int STEP_Z [NSIDES] = '{0, 0, 1, -1, 0, 0};
  localparam int ORG_X  [NSIDES] = '{0, 0, 0, 0, 1, 0};
  localparam int ORG_Y  [NSIDES] = '{1, 0, 1, 0, 0, 1};
  localparam int ORG_Z  [NSIDES] = '{0, 1, 1, 0, 0, 0};

  typedef struct packed {
    logic [SIDE_W-1:0]  side;
    logic [CRN_X_W-1:0] cx;
    logic [CRN_Y_W-1:0] cy;
    logic [CRN_Z_W-1:0] cz;
    logic [QUAD_W-1:0]  quad;
    logic               last;
  } face_word_t;

  logic clk;
  logic rst;

  vfcm_req_if  req_bus ();
  vfcm_face_if face_bus ();
  vfcm_cfg_if  cfg_bus ();

  voxel_face_cull_mesher_unit uut (
    .clk  (clk),
    .rst  (rst),
    .req  (req_bus),
    .face (face_bus),
    .cfg  (cfg_bus)
  );

  bit                  grid_occ [GRID_CELLS];
  bit                  grid_set [GRID_CELLS];
  logic [SIZE_X_W-1:0] ext_x;
  logic [SIZE_Y_W-1:0] ext_y;
  logic [SIZE_Z_W-1:0] ext_z;
  logic [QUAD_W-1:0]   quad_next;
  face_word_t          faces_due [$];
  face_word_t          want_face;

  int errors = 0;
  int words_sent;
  int idle_cycles = 0;
  bit calm;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int clip(int v, int lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic bit in_chunk(int x, int y, int z);
    return x >= 0 && y >= 0 && z >= 0 &&
           x < clip(int'(ext_x), DEF_MAX_X) && y < clip(int'(ext_y), DEF_MAX_Y) &&
           z < clip(int'(ext_z), DEF_MAX_Z);
  endfunction

  function automatic int cell_idx(int x, int y, int z);
    return x + DEF_MAX_X * (y + DEF_MAX_Y * z);
  endfunction

  function automatic bit solid(int x, int y, int z);
    if (!in_chunk(x, y, z)) begin
      return 1'b0;
    end
    return grid_occ[cell_idx(x, y, z)];
  endfunction

  // updates grid and counter for one accepted word, queues its face words
  function automatic void predict_word(logic [1:0] kind, int x, int y, int z, bit occ);
    face_word_t batch [$];
    face_word_t w;
    case (kind)
      REQ_WRITE: begin
        if (in_chunk(x, y, z)) begin
          grid_occ[cell_idx(x, y, z)] = occ;
          grid_set[cell_idx(x, y, z)] = 1'b1;
        end
      end
      REQ_RESTART: begin
        quad_next = '0;
      end
      REQ_MESH: begin
        if (solid(x, y, z)) begin
          for (int s = 0; s < NSIDES; s++) begin
            if (!solid(x + STEP_X[s], y + STEP_Y[s], z + STEP_Z[s])) begin
              w.side = SIDE_SEQ[s];
              w.cx   = CRN_X_W'(x + ORG_X[s]);
              w.cy   = CRN_Y_W'(y + ORG_Y[s]);
              w.cz   = CRN_Z_W'(z + ORG_Z[s]);
              w.quad = quad_next;
              w.last = 1'b0;
              batch.push_back(w);
              quad_next = quad_next + QUAD_W'(1);
            end
          end
          if (batch.size() > 0) begin
            batch[batch.size() - 1].last = 1'b1;
          end
          foreach (batch[i]) faces_due.push_back(batch[i]);
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void field_check(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  task automatic send_word(logic [1:0] kind, int x, int y, int z, bit occ);
    if (!calm && $urandom_range(0, 99) < 24) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= kind;
    req_bus.pos_x    <= POS_X_W'(x);
    req_bus.pos_y    <= POS_Y_W'(y);
    req_bus.pos_z    <= POS_Z_W'(z);
    req_bus.occupied <= occ;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    predict_word(kind, x, y, z, occ);
    words_sent++;
  endtask

  task automatic cfg_word(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] value, bit hold);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      REG_SIZE_X: ext_x = value[SIZE_X_W-1:0];
      REG_SIZE_Y: ext_y = value[SIZE_Y_W-1:0];
      REG_SIZE_Z: ext_z = value[SIZE_Z_W-1:0];
      default: begin
      end
    endcase
    if (!hold) begin
      cfg_bus.valid <= 1'b0;
    end
  endtask

  task automatic set_extent(logic [CFG_DW-1:0] sx, logic [CFG_DW-1:0] sy,
                            logic [CFG_DW-1:0] sz, bit stray);
    cfg_word(REG_SIZE_X, sx, 1'b1);
    cfg_word(REG_SIZE_Y, sy, 1'b1);
    cfg_word(REG_SIZE_Z, sz, stray);
    if (stray) begin
      cfg_word(REG_SPARE, CFG_DW'($urandom_range(0, 127)), 1'b0);
    end
  endtask

  // drop valid, wait out pending faces and any trailing no-result words
  task automatic settle();
    req_bus.valid <= 1'b0;
    while (faces_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic prep_cell(int x, int y, int z, bit occ);
    if (in_chunk(x, y, z) && !grid_set[cell_idx(x, y, z)]) begin
      send_word(REQ_WRITE, x, y, z, occ);
    end
  endtask

  // write any unwritten cell the mesh would read, then mesh
  task automatic mesh_prepared(int x, int y, int z);
    prep_cell(x, y, z, $urandom_range(0, 9) < 7);
    for (int s = 0; s < NSIDES; s++) begin
      prep_cell(x + STEP_X[s], y + STEP_Y[s], z + STEP_Z[s], 1'($urandom_range(0, 1)));
    end
    send_word(REQ_MESH, x, y, z, 1'($urandom_range(0, 1)));
  endtask

  // mostly near a chunk corner so written cells get reused
  function automatic int pick(int e);
    int span;
    span = (e < 4) ? e : 4;
    if ($urandom_range(0, 2) == 0) begin
      return $urandom_range(0, e - 1);
    end
    if ($urandom_range(0, 1) == 1) begin
      return $urandom_range(0, span - 1);
    end
    return e - 1 - int'($urandom_range(0, span - 1));
  endfunction

  task automatic random_step();
    int r;
    int x;
    int y;
    int z;
    r = $urandom_range(0, 99);
    if (r < 62) begin
      x = pick(clip(int'(ext_x), DEF_MAX_X));
      y = pick(clip(int'(ext_y), DEF_MAX_Y));
      z = pick(clip(int'(ext_z), DEF_MAX_Z));
      if ($urandom_range(0, 3) == 0) begin
        send_word(REQ_WRITE, x, y, z, $urandom_range(0, 9) < 7);
      end
      mesh_prepared(x, y, z);
    end else if (r < 80) begin
      send_word(REQ_WRITE, $urandom_range(0, 15), $urandom_range(0, 63),
                $urandom_range(0, 15), 1'($urandom_range(0, 1)));
    end else if (r < 88) begin
      mesh_prepared($urandom_range(0, 15), $urandom_range(0, 63), $urandom_range(0, 15));
    end else if (r < 94) begin
      send_word(REQ_RESTART, $urandom_range(0, 15), $urandom_range(0, 63),
                $urandom_range(0, 15), 1'($urandom_range(0, 1)));
    end else begin
      send_word(REQ_UNKNOWN, $urandom_range(0, 15), $urandom_range(0, 63),
                $urandom_range(0, 15), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_visible_faces();
    send_word(REQ_WRITE, 0, 0, 0, 1'b1);
    send_word(REQ_WRITE, 1, 0, 0, 1'b0);
    send_word(REQ_WRITE, 0, 1, 0, 1'b0);
    send_word(REQ_WRITE, 0, 0, 1, 1'b0);
    send_word(REQ_MESH, 0, 0, 0, 1'b0);
    send_word(REQ_WRITE, 15, 63, 15, 1'b1);
    send_word(REQ_WRITE, 14, 63, 15, 1'b0);
    send_word(REQ_WRITE, 15, 62, 15, 1'b0);
    send_word(REQ_WRITE, 15, 63, 14, 1'b0);
    send_word(REQ_MESH, 15, 63, 15, 1'b1);
    // buried voxel: no faces, counter holds
    send_word(REQ_WRITE, 5, 5, 5, 1'b1);
    for (int s = 0; s < NSIDES; s++) begin
      send_word(REQ_WRITE, 5 + STEP_X[s], 5 + STEP_Y[s], 5 + STEP_Z[s], 1'b1);
    end
    send_word(REQ_MESH, 5, 5, 5, 1'b0);
    send_word(REQ_RESTART, 0, 0, 0, 1'b0);
    send_word(REQ_UNKNOWN, 15, 63, 15, 1'b1);
    send_word(REQ_MESH, 0, 0, 0, 1'b0);
  endtask

  task automatic test_extent_edges();
    settle();
    set_extent(7'd1, 7'd1, 7'd1, 1'b1);
    send_word(REQ_MESH, 0, 0, 0, 1'b0);
    send_word(REQ_WRITE, 1, 0, 0, 1'b1);
    send_word(REQ_MESH, 3, 2, 1, 1'b1);
    settle();
    set_extent(7'd0, 7'd64, 7'd16, 1'b0);
    send_word(REQ_MESH, 0, 0, 0, 1'b0);
    send_word(REQ_WRITE, 0, 0, 0, 1'b0);
    settle();
    set_extent(7'h7F, 7'h7F, 7'h7F, 1'b0);
    send_word(REQ_MESH, 15, 63, 15, 1'b0);
    send_word(REQ_MESH, 0, 0, 0, 1'b0);
  endtask

  task automatic test_random_sweep();
    int sx [6] = '{3, 16, 2, 16, 1, 5};
    int sy [6] = '{3, 64, 6, 1, 64, 5};
    int sz [6] = '{3, 16, 4, 16, 1, 5};
    int start;
    for (int p = 0; p < 6; p++) begin
      settle();
      set_extent(CFG_DW'(sx[p]), CFG_DW'(sy[p]), CFG_DW'(sz[p]), p == 2);
      calm  = (p == 5);
      start = words_sent;
      while (words_sent - start < PHASE_WORDS) random_step();
      calm = 1'b0;
    end
  endtask

  initial begin
    face_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      face_bus.ready <= calm || ($urandom_range(0, 99) >= 24);
    end
  end

  always @(posedge clk) begin
    if (!rst && face_bus.valid && face_bus.ready) begin
      if (faces_due.size() == 0) begin
        $display("%0t: unexpected face word side %0d corner %0d,%0d,%0d quad %0d last %0d",
                 $time, face_bus.face_side, face_bus.corner_x, face_bus.corner_y,
                 face_bus.corner_z, face_bus.quad_index, face_bus.last);
        errors++;
      end else begin
        want_face = faces_due.pop_front();
        field_check("face_side", 32'(want_face.side), 32'(face_bus.face_side));
        field_check("corner_x", 32'(want_face.cx), 32'(face_bus.corner_x));
        field_check("corner_y", 32'(want_face.cy), 32'(face_bus.corner_y));
        field_check("corner_z", 32'(want_face.cz), 32'(face_bus.corner_z));
        field_check("quad_index", 32'(want_face.quad), 32'(face_bus.quad_index));
        field_check("last", 32'(want_face.last), 32'(face_bus.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((req_bus.valid && req_bus.ready) || (face_bus.valid && face_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst              <= 1'b1;
    req_bus.valid    <= 1'b0;
    req_bus.req_type <= REQ_WRITE;
    req_bus.pos_x    <= '0;
    req_bus.pos_y    <= '0;
    req_bus.pos_z    <= '0;
    req_bus.occupied <= 1'b0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.index    <= REG_SIZE_X;
    cfg_bus.data     <= '0;
    words_sent  = 0;
    calm        = 1'b0;
    ext_x       = RST_SIZE_X;
    ext_y       = RST_SIZE_Y;
    ext_z       = RST_SIZE_Z;
    quad_next   = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_visible_faces();
    test_extent_edges();
    test_random_sweep();
    settle();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
